// ----- rtl/mvsm_pkg.sv -----
// Package: shared types, constants and opcodes for the voice mixer.
`timescale 1ns / 1ps
package mvsm_pkg;

	localparam int unsigned NumVoicesDef      = 256;
	localparam int unsigned SamplesPerVoiceDef = 1024;
	localparam int unsigned QueueDepthDef     = 4;
	localparam int unsigned VoiceW  = 8;
	localparam int unsigned SampleW = 16;
	localparam int unsigned GainW   = 16;
	localparam int unsigned OutW    = 24;
	localparam int unsigned OpW     = 3;

	typedef enum logic [OpW-1:0] {
		OP_GAIN  = 3'd0,
		OP_LOAD  = 3'd1,
		OP_PLAY  = 3'd2,
		OP_STOP  = 3'd3,
		OP_MIX   = 3'd4
	} op_t;

	typedef struct packed {
		logic [OpW-1:0]            operation;
		logic [VoiceW-1:0]         voice;
		logic [GainW-1:0]          gain_left;
		logic [GainW-1:0]          gain_right;
		logic                      loop_enable;
		logic signed [SampleW-1:0] sample_value;
		logic                      first_sample;
		logic signed [OutW-1:0]    bed_left;
		logic signed [OutW-1:0]    bed_right;
	} in_word_t;

	typedef struct packed {
		logic signed [OutW-1:0] mix_left;
		logic signed [OutW-1:0] mix_right;
		logic                   clipped;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CMD,
		ST_WALK,
		ST_DRAIN,
		ST_OUT
	} back_state_t;

endpackage

// ----- rtl/multi_voice_sample_mixer_unit.sv -----
// A command reads its voice table entry in ST_IDLE and writes it back in ST_CMD;
// a mix frame leaves the queue and runs ST_WALK, ST_DRAIN and ST_OUT into its word.
// The voice walk moves one voice a cycle through table and sample memory; no queue
// entry is taken before ST_IDLE, nor a mix frame while a result is still pending.
// Reset: arst_n clears the queue and starts a clearing pass over all NumVoices
// voice table entries; sample memory is not reset.
`timescale 1ns / 1ps
module multi_voice_sample_mixer_unit #(
	parameter int unsigned NumVoices       = mvsm_pkg::NumVoicesDef,
	parameter int unsigned SamplesPerVoice = mvsm_pkg::SamplesPerVoiceDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  mvsm_pkg::in_word_t  in_word,
	output logic                out_valid,
	input  logic                out_stall,
	output mvsm_pkg::out_word_t out_word
);
	import mvsm_pkg::*;

	logic     q_valid, q_take;
	in_word_t q_word;

	mvsm_front #(.Depth(QueueDepthDef)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_word,
		.q_valid, .q_take, .q_word
	);

	mvsm_back #(.NumVoices(NumVoices), .SamplesPerVoice(SamplesPerVoice)) u_back (
		.clk, .arst_n, .q_valid, .q_take, .q_word,
		.out_valid, .out_stall, .out_word
	);

`ifndef ASSERT_OFF
	// Engine never takes from an empty queue.
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		q_take |-> q_valid) else $error("take from empty queue");
	// A pending result is not overwritten by a new one.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid) else $error("result lost");
`endif
endmodule

// ----- rtl/mvsm_front.sv -----
// Front end: command queue toward the engine.
`timescale 1ns / 1ps
module mvsm_front #(
	parameter int unsigned Depth = mvsm_pkg::QueueDepthDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  mvsm_pkg::in_word_t  in_word,
	output logic                q_valid,
	input  logic                q_take,
	output mvsm_pkg::in_word_t  q_word
);
	import mvsm_pkg::*;

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

	in_word_t             fifo_q [Depth];
	logic [PtrW-1:0]      wr_q, rd_q;
	logic [PtrW:0]        cnt_q;
	logic                 push, pop;
	logic                 keep;

	// Drop unused opcodes at the door.
	assign keep     = (in_word.operation <= OP_MIX);
	assign in_stall = (cnt_q == (PtrW+1)'(Depth));
	assign push     = in_valid && !in_stall && keep;
	assign pop      = q_take && q_valid;
	assign q_valid  = (cnt_q != '0);
	assign q_word   = fifo_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_q] <= in_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
			if (pop)  rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
			cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
		end
	end
endmodule

// ----- rtl/mvsm_back.sv -----
// Back end: voice table, sample memory, mix walk and output register.
`timescale 1ns / 1ps
module mvsm_back #(
	parameter int unsigned NumVoices       = mvsm_pkg::NumVoicesDef,
	parameter int unsigned SamplesPerVoice = mvsm_pkg::SamplesPerVoiceDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	output logic                q_take,
	input  mvsm_pkg::in_word_t  q_word,
	output logic                out_valid,
	input  logic                out_stall,
	output mvsm_pkg::out_word_t out_word
);
	import mvsm_pkg::*;

	localparam int unsigned VW   = (NumVoices > 1) ? $clog2(NumVoices) : 1;
	localparam int unsigned PW   = (SamplesPerVoice > 1) ? $clog2(SamplesPerVoice) : 1;
	localparam int unsigned LW   = $clog2(SamplesPerVoice + 1);
	localparam int unsigned AW   = VW + PW;
	localparam int unsigned MemD = 1 << AW;
	localparam int unsigned AccW = SampleW + GainW + 1 + VW + 1;

	// One voice table entry.
	typedef struct packed {
		logic [LW-1:0]    len;
		logic [LW-1:0]    pos;
		logic             play;
		logic             loop;
		logic [GainW-1:0] gl;
		logic [GainW-1:0] gr;
	} voice_t;

	voice_t             vtab [NumVoices];
	logic [SampleW-1:0] mem [MemD];

	back_state_t st_q, st_d;
	logic [VW:0]      idx_q;
	logic [VW-1:0]    vi;
	voice_t           vs_s1;
	logic             val_s1, act_s2, act_s3;
	logic [VW-1:0]    v_s1;
	logic [SampleW-1:0] rd_s2;
	logic [GainW-1:0] gl_s2, gr_s2;
	logic signed [SampleW+GainW:0] pl_s3, pr_s3;
	logic signed [AccW-1:0] accl_q, accr_q;
	logic signed [OutW-1:0] bedl_q, bedr_q;
	out_word_t        res_q;
	logic             res_v_q;

	logic             cmd_ok, walk_done, vact, vwrap, vstop, mix_start;
	logic [VW-1:0]    cv;
	logic [LW-1:0]    rpos;
	logic [AW-1:0]    rd_addr, wr_addr;
	logic             wr_en;
	logic [LW-1:0]    wlen;
	logic             wlen_ok;
	logic [VW-1:0]    vt_ra, vt_wa;
	logic             vt_we;
	voice_t           vt_wd, walk_new, cmd_new;
	logic signed [AccW-16:0] shl, shr;
	logic signed [AccW-14:0] tl, tr;
	logic             cl_hi, cl_lo, cr_hi, cr_lo;
	localparam logic signed [AccW-14:0] OMax = (AccW-13)'(8388607);
	localparam logic signed [AccW-14:0] OMin = -(AccW-13)'(8388608);

	assign cv     = q_word.voice[VW-1:0];
	assign cmd_ok = (32'(q_word.voice) < NumVoices);
	assign vi     = idx_q[VW-1:0];
	assign walk_done = (idx_q == (VW+1)'(NumVoices));

	// Walk stage 1: decide contribution and read position from the table entry.
	assign vwrap = (vs_s1.pos >= vs_s1.len);
	assign vact  = vs_s1.play && (vs_s1.len != '0) && !(vwrap && !vs_s1.loop);
	assign vstop = vs_s1.play && (vs_s1.len != '0) && vwrap && !vs_s1.loop;
	assign rpos  = vwrap ? '0 : vs_s1.pos;
	assign rd_addr = {v_s1, rpos[PW-1:0]};

	always_comb begin
		walk_new = vs_s1;
		if (vstop) walk_new.play = 1'b0;
		if (vact)  walk_new.pos  = rpos + LW'(1);
	end

	// Command path: buffer position after an optional restart.
	assign wlen    = q_word.first_sample ? '0 : vs_s1.len;
	assign wlen_ok = (32'(wlen) < SamplesPerVoice);
	assign wr_addr = {cv, wlen[PW-1:0]};

	always_comb begin
		cmd_new = vs_s1;
		case (q_word.operation)
			OP_GAIN: begin
				cmd_new.gl   = q_word.gain_left;
				cmd_new.gr   = q_word.gain_right;
				cmd_new.loop = q_word.loop_enable;
			end
			OP_LOAD: begin
				if (q_word.first_sample) begin
					cmd_new.pos  = '0;
					cmd_new.play = 1'b1;
				end
				cmd_new.len = wlen_ok ? wlen + LW'(1) : wlen;
			end
			OP_PLAY: cmd_new.play = 1'b1;
			OP_STOP: begin
				cmd_new.play = 1'b0;
				cmd_new.pos  = '0;
			end
			default: ;
		endcase
	end

	// Next state.
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_CLEAR: if (idx_q == (VW+1)'(NumVoices - 1)) st_d = ST_IDLE;
			ST_IDLE: begin
				if (q_valid) begin
					if (q_word.operation != OP_MIX) st_d = ST_CMD;
					else if (!res_v_q) st_d = ST_WALK;
				end
			end
			ST_CMD:   st_d = ST_IDLE;
			ST_WALK:  if (walk_done) st_d = ST_DRAIN;
			ST_DRAIN: if (!val_s1 && !act_s2 && !act_s3) st_d = ST_OUT;
			ST_OUT:   st_d = ST_IDLE;
			default:  st_d = ST_IDLE;
		endcase
	end

	// State outputs: queue take, table port and sample write.
	always_comb begin
		q_take    = 1'b0;
		mix_start = 1'b0;
		wr_en     = 1'b0;
		vt_ra     = cv;
		vt_we     = val_s1;
		vt_wa     = v_s1;
		vt_wd     = walk_new;
		case (st_q)
			ST_CLEAR: begin
				vt_we = 1'b1;
				vt_wa = vi;
				vt_wd = '0;
			end
			ST_IDLE: begin
				if (q_valid && q_word.operation == OP_MIX && !res_v_q) begin
					q_take    = 1'b1;
					mix_start = 1'b1;
				end
			end
			ST_CMD: begin
				q_take = q_valid;
				vt_we  = q_valid && cmd_ok;
				vt_wa  = cv;
				vt_wd  = cmd_new;
				wr_en  = q_valid && cmd_ok && (q_word.operation == OP_LOAD) && wlen_ok;
			end
			ST_WALK: vt_ra = vi;
			default: ;
		endcase
	end

	// Voice table: one registered read, one write a cycle.
	always_ff @(posedge clk) begin
		if (vt_we) vtab[vt_wa] <= vt_wd;
		vs_s1 <= vtab[vt_ra];
		v_s1  <= vi;
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= q_word.sample_value;
		rd_s2 <= mem[rd_addr];
	end

	// Saturation of the final sums.
	always_comb begin
		shl = $signed(accl_q[AccW-1:15]);
		shr = $signed(accr_q[AccW-1:15]);
		tl  = (AccW-13)'(shl) + (AccW-13)'(bedl_q);
		tr  = (AccW-13)'(shr) + (AccW-13)'(bedr_q);
		cl_hi = tl > OMax;
		cl_lo = tl < OMin;
		cr_hi = tr > OMax;
		cr_lo = tr < OMin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_CLEAR;
			idx_q   <= '0;
			val_s1  <= 1'b0;
			act_s2  <= 1'b0;
			act_s3  <= 1'b0;
			res_v_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (res_v_q && !out_stall) res_v_q <= 1'b0;
			if (st_q == ST_OUT) res_v_q <= 1'b1;
			val_s1 <= (st_q == ST_WALK) && !walk_done;
			act_s2 <= val_s1 && vact;
			act_s3 <= act_s2;
			if (st_q == ST_IDLE) idx_q <= '0;
			else if (st_q == ST_CLEAR || (st_q == ST_WALK && !walk_done))
				idx_q <= idx_q + (VW+1)'(1);
		end
	end

	// Datapath: gains and sample to s2, products to s3, accumulate.
	always_ff @(posedge clk) begin
		gl_s2 <= vs_s1.gl;
		gr_s2 <= vs_s1.gr;
		pl_s3 <= $signed(rd_s2) * $signed({1'b0, gl_s2});
		pr_s3 <= $signed(rd_s2) * $signed({1'b0, gr_s2});
		if (mix_start) begin
			accl_q <= '0;
			accr_q <= '0;
			bedl_q <= q_word.bed_left;
			bedr_q <= q_word.bed_right;
		end else if (act_s3) begin
			accl_q <= accl_q + AccW'(pl_s3);
			accr_q <= accr_q + AccW'(pr_s3);
		end
		if (st_q == ST_OUT) begin
			res_q.mix_left  <= cl_hi ? OutW'(OMax) : cl_lo ? OutW'(OMin) : tl[OutW-1:0];
			res_q.mix_right <= cr_hi ? OutW'(OMax) : cr_lo ? OutW'(OMin) : tr[OutW-1:0];
			res_q.clipped   <= cl_hi | cl_lo | cr_hi | cr_lo;
		end
	end

	assign out_valid = res_v_q;
	assign out_word  = res_q;
endmodule
